FILE: rtl/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// Types and constants shared by the buddy allocator modules.
// ----------------------------------------------------------------------------
package bma_pkg;

  localparam int unsigned MemBytes  = 1024;
  localparam int unsigned Levels    = 10;
  localparam int unsigned NodeCount = 2 * MemBytes - 1;
  localparam int unsigned IdxW      = 11;
  localparam int unsigned AddrW     = 10;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned LvlW      = 4;

  typedef enum logic [1:0] {
    K_ABSENT = 2'd0,
    K_FREE   = 2'd1,
    K_USED   = 2'd2,
    K_SPLIT  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOBLOCK = 2'd2,
    ST_BADSIZE = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SIZE,
    S_SRD,
    S_SCHK,
    S_SPLIT_P,
    S_SPLIT_R,
    S_FRD,
    S_FCHK,
    S_MRD,
    S_MCHK,
    S_MW0,
    S_MW1,
    S_MW2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    kind_e           wdata;
    logic [IdxW-1:0] raddr;
  } ram_ctl_t;

endpackage

FILE: rtl/bma_node_ram.sv
// ----------------------------------------------------------------------------
// bma_node_ram
// Node kind store of the buddy tree, one write and one registered read port.
// ----------------------------------------------------------------------------
module bma_node_ram
  import bma_pkg::*;
(
  input  logic     clk_i,
  input  ram_ctl_t ctl_i,
  output kind_e    rdata_o
);

  kind_e mem [NodeCount];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[ctl_i.waddr] <= ctl_i.wdata;
    end
    rdata_o <= mem[ctl_i.raddr];
  end

endmodule

FILE: rtl/buddy_memory_allocator.sv
// ----------------------------------------------------------------------------
// buddy_memory_allocator
// Binary buddy allocator, best fit with lowest address on ties.
// An alloc scans the tree nodes of each level, then splits down to the
// fitting size; a free walks down the tree levels, then merges buddies.
// One request word at a time; all steps share the node RAM ports.
// After reset a clearing pass sweeps all 2047 nodes of the node RAM.
// ----------------------------------------------------------------------------
module buddy_memory_allocator
  import bma_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [10:0]       req_size_i,
  input  logic [9:0]        free_addr_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [9:0]        block_start_o,
  output logic [9:0]        block_end_o,
  output logic [10:0]       block_size_o
);

  state_e state_q, state_d;
  logic [SizeW-1:0] req_q, req_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [LvlW-1:0]  lvl_q, lvl_d;
  logic [AddrW-1:0] k_q, k_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [AddrW-1:0] start_q, start_d;
  logic [SizeW-1:0] size_q, size_d;
  status_e          stat_q, stat_d;
  logic             out_valid_q, out_valid_d;

  ram_ctl_t ctl;
  kind_e    rdata;

  logic             accept, out_free, k_last;
  logic [IdxW-1:0]  base, sib, parent, left, right;
  logic [SizeW-1:0] half;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign base     = IdxW'((12'd1 << lvl_q) - 12'd1);
  assign k_last   = ({1'b0, k_q} == base);
  assign sib      = idx_q[0] ? idx_q + 1'b1 : idx_q - 1'b1;
  assign parent   = (idx_q - 1'b1) >> 1;
  assign left     = IdxW'({idx_q, 1'b0} + 12'd1);
  assign right    = IdxW'({idx_q, 1'b0} + 12'd2);
  assign half     = size_q >> 1;

  bma_node_ram u_ram (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (idx_q == IdxW'(NodeCount - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (op_i) state_d = S_FRD;
          else if (req_size_i == '0 || req_size_i > SizeW'(MemBytes)) state_d = S_DONE;
          else state_d = S_SIZE;
        end
      end
      S_SIZE:    if (size_q >= req_q) state_d = S_SRD;
      S_SRD:     state_d = S_SCHK;
      S_SCHK: begin
        if (rdata == K_FREE) state_d = S_SPLIT_P;
        else if (k_last && lvl_q == '0) state_d = S_DONE;
        else state_d = S_SRD;
      end
      S_SPLIT_P: state_d = (half >= req_q) ? S_SPLIT_R : S_DONE;
      S_SPLIT_R: state_d = S_SPLIT_P;
      S_FRD:     state_d = S_FCHK;
      S_FCHK: begin
        if (rdata == K_SPLIT && size_q >= SizeW'(2)) state_d = S_FRD;
        else if (rdata == K_USED && start_q == addr_q) state_d = S_MRD;
        else state_d = S_DONE;
      end
      S_MRD:     state_d = (idx_q == '0) ? S_DONE : S_MCHK;
      S_MCHK:    state_d = (rdata == K_FREE) ? S_MW0 : S_DONE;
      S_MW0:     state_d = S_MW1;
      S_MW1:     state_d = S_MW2;
      S_MW2:     state_d = S_MRD;
      S_DONE:    if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_d       = req_q;
    addr_d      = addr_q;
    lvl_d       = lvl_q;
    k_d         = k_q;
    idx_d       = idx_q;
    start_d     = start_q;
    size_d      = size_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl.we      = 1'b0;
    ctl.waddr   = idx_q;
    ctl.wdata   = K_ABSENT;
    ctl.raddr   = idx_q;
    case (state_q)
      S_CLEAR: begin
        ctl.we    = 1'b1;
        ctl.wdata = (idx_q == '0) ? K_FREE : K_ABSENT;
        idx_d     = idx_q + 1'b1;
      end
      S_IDLE: begin
        idx_d = '0;
        if (accept) begin
          req_d   = req_size_i;
          addr_d  = free_addr_i;
          lvl_d   = LvlW'(Levels);
          size_d  = SizeW'(1);
          start_d = '0;
          stat_d  = ST_OK;
          if (op_i) begin
            size_d = SizeW'(MemBytes);
          end else if (req_size_i == '0 || req_size_i > SizeW'(MemBytes)) begin
            stat_d = ST_BADSIZE;
          end
        end
      end
      S_SIZE: begin
        k_d = '0;
        if (size_q < req_q) begin
          lvl_d  = lvl_q - 1'b1;
          size_d = size_q << 1;
        end
      end
      S_SRD: begin
        idx_d     = base + IdxW'(k_q);
        ctl.raddr = base + IdxW'(k_q);
      end
      S_SCHK: begin
        if (rdata == K_FREE) begin
          start_d = AddrW'(k_q << (LvlW'(Levels) - lvl_q));
        end else if (k_last) begin
          if (lvl_q == '0) begin
            stat_d = ST_NOSPACE;
          end else begin
            lvl_d  = lvl_q - 1'b1;
            size_d = size_q << 1;
            k_d    = '0;
          end
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      S_SPLIT_P: begin
        ctl.we    = 1'b1;
        ctl.wdata = (half >= req_q) ? K_SPLIT : K_USED;
      end
      S_SPLIT_R: begin
        ctl.we    = 1'b1;
        ctl.waddr = right;
        ctl.wdata = K_FREE;
        idx_d     = left;
        size_d    = half;
      end
      S_FCHK: begin
        if (rdata == K_SPLIT && size_q >= SizeW'(2)) begin
          size_d = half;
          if ({1'b0, addr_q} >= {1'b0, start_q} + half) begin
            idx_d   = right;
            start_d = start_q + AddrW'(half);
          end else begin
            idx_d = left;
          end
        end else if (rdata == K_USED && start_q == addr_q) begin
          ctl.we    = 1'b1;
          ctl.wdata = K_FREE;
        end else begin
          stat_d = ST_NOBLOCK;
        end
      end
      S_MRD:  ctl.raddr = sib;
      S_MW0:  ctl.we = 1'b1;
      S_MW1: begin
        ctl.we    = 1'b1;
        ctl.waddr = sib;
      end
      S_MW2: begin
        ctl.we    = 1'b1;
        ctl.waddr = parent;
        ctl.wdata = K_FREE;
        idx_d     = parent;
      end
      S_DONE: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    addr_q  <= addr_d;
    lvl_q   <= lvl_d;
    k_q     <= k_d;
    start_q <= start_d;
    size_q  <= size_d;
    stat_q  <= stat_d;
    if (state_q == S_DONE && out_free) begin
      status_o <= stat_q;
      if (stat_q == ST_OK) begin
        block_start_o <= start_q;
        block_end_o   <= AddrW'({1'b0, start_q} + size_q - 1'b1);
        block_size_o  <= size_q;
      end else begin
        block_start_o <= '0;
        block_end_o   <= '0;
        block_size_o  <= '0;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Buddy allocator test: directed alloc/free corner cases, then random
// alloc/free traffic, mostly well-formed, with random idling on both channels
// and a long output hold-off. A tree model in the scoreboard predicts every result.
// ----------------------------------------------------------------------------
module tb;
  import bma_pkg::*;

  typedef struct {
    status_e         st;
    logic [9:0]      start;
    logic [9:0]      blk_end;
    logic [10:0]     size;
  } blk_res_t;

  class alloc_scoreboard;
    kind_e    tree[NodeCount];
    blk_res_t pending_q[$];
    int       errors;
    int       n_ok;
    int       n_err;

    function new();
      foreach (tree[i]) tree[i] = K_ABSENT;
      tree[0] = K_FREE;
      errors = 0;
      n_ok = 0;
      n_err = 0;
    endfunction

    function blk_res_t make_res(status_e st, int unsigned start, int unsigned size);
      blk_res_t r;
      r.st      = st;
      r.start   = start[9:0];
      r.size    = size[10:0];
      r.blk_end = (size == 0) ? 10'd0 : 10'(start + size - 1);
      return r;
    endfunction

    function blk_res_t run_alloc(int unsigned req);
      int unsigned idx, start, size, sz, base;
      bit found;
      idx = 0; start = 0; size = 0; found = 0;
      if (req == 0 || req > MemBytes) return make_res(ST_BADSIZE, 0, 0);
      for (int l = Levels; l >= 0 && !found; l--) begin
        sz = MemBytes >> l;
        base = (1 << l) - 1;
        if (sz < req) continue;
        for (int unsigned k = 0; k < (1 << l); k++) begin
          if (tree[base + k] == K_FREE) begin
            idx = base + k; start = k * sz; size = sz; found = 1;
            break;
          end
        end
      end
      if (!found) return make_res(ST_NOSPACE, 0, 0);
      while (size / 2 >= req && 2 * idx + 2 < NodeCount) begin
        tree[idx] = K_SPLIT;
        tree[2 * idx + 1] = K_FREE;
        tree[2 * idx + 2] = K_FREE;
        idx = 2 * idx + 1;
        size = size / 2;
      end
      tree[idx] = K_USED;
      return make_res(ST_OK, start, size);
    endfunction

    function blk_res_t run_free(int unsigned addr);
      int unsigned idx, start, size, half, sib, par;
      blk_res_t r;
      idx = 0; start = 0; size = MemBytes;
      while (tree[idx] == K_SPLIT && size >= 2) begin
        half = size / 2;
        if (addr >= start + half) begin
          idx = 2 * idx + 2;
          start += half;
        end else begin
          idx = 2 * idx + 1;
        end
        size = half;
      end
      if (tree[idx] != K_USED || start != addr) return make_res(ST_NOBLOCK, 0, 0);
      r = make_res(ST_OK, start, size);
      tree[idx] = K_FREE;
      while (idx > 0) begin
        sib = idx[0] ? idx + 1 : idx - 1;
        par = (idx - 1) / 2;
        if (tree[sib] != K_FREE) break;
        tree[idx] = K_ABSENT;
        tree[sib] = K_ABSENT;
        tree[par] = K_FREE;
        idx = par;
      end
      return r;
    endfunction

    function blk_res_t note_word(bit op, logic [10:0] req, logic [9:0] addr);
      blk_res_t r;
      r = op ? run_free(addr) : run_alloc(req);
      pending_q.push_back(r);
      return r;
    endfunction

    function void check_word(logic [1:0] st, logic [9:0] start, logic [9:0] e,
                             logic [10:0] size);
      blk_res_t x;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word st=%0d start=%0d", $time, st, start);
        errors++;
        return;
      end
      x = pending_q.pop_front();
      if (x.st == ST_OK) n_ok++; else n_err++;
      if (st !== x.st) begin
        $display("%0t: status exp %0d got %0d", $time, x.st, st); errors++;
      end
      if (start !== x.start) begin
        $display("%0t: start exp %0d got %0d", $time, x.start, start); errors++;
      end
      if (e !== x.blk_end) begin
        $display("%0t: end exp %0d got %0d", $time, x.blk_end, e); errors++;
      end
      if (size !== x.size) begin
        $display("%0t: size exp %0d got %0d", $time, x.size, size); errors++;
      end
    endfunction
  endclass

  localparam int unsigned CycleLimit = 40_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [10:0] req_size_i = '0;
  logic [9:0]  free_addr_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [9:0]  block_start_o;
  logic [9:0]  block_end_o;
  logic [10:0] block_size_o;

  alloc_scoreboard sb = new();
  int unsigned live_q[$];
  int unsigned cycles = 0;
  int          words_sent = 0;
  bit          hold = 1'b0;
  int          stall_left = 0;

  buddy_memory_allocator dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send(bit op, logic [10:0] req, logic [9:0] addr);
    int g;
    blk_res_t r;
    g = gap_len();
    if (g > 0) begin
      @(negedge clk_i);
      in_valid_i  = 1'b0;
      op_i        = 1'($urandom);
      req_size_i  = 11'($urandom);
      free_addr_i = 10'($urandom);
      repeat (g - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i  = 1'b1;
    op_i        = op;
    req_size_i  = req;
    free_addr_i = addr;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    r = sb.note_word(op, req, addr);
    words_sent++;
    if (r.st == ST_OK) begin
      if (!op) live_q.push_back(r.start);
      else foreach (live_q[i]) if (live_q[i] == r.start) begin
        live_q.delete(i);
        break;
      end
    end
  endtask

  task automatic alloc(int unsigned sz);
    send(1'b0, sz[10:0], 10'($urandom));
  endtask

  task automatic release_blk(int unsigned a);
    send(1'b1, 11'($urandom), a[9:0]);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_word(status_o, block_start_o, block_end_o, block_size_o);

  always @(negedge clk_i) begin
    if (hold) begin
      out_stall_i = 1'b1;
    end else if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      if ($urandom_range(0, 99) < 15) stall_left = gap_len();
    end
  end

  // long output hold-off while the sender keeps offering words
  initial begin
    wait (words_sent == 300);
    hold = 1'b1;
    repeat (6000) @(negedge clk_i);
    hold = 1'b0;
  end

  initial begin
    int r;
    int unsigned sz;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    alloc(0);
    alloc(2047);
    alloc(1025);
    alloc(1024);
    alloc(1);
    release_blk(1023);
    release_blk(0);
    release_blk(0);
    alloc(1);
    alloc(1);
    alloc(3);
    release_blk(5);
    release_blk(2);
    release_blk(1);
    release_blk(0);
    release_blk(4);
    alloc(512);
    alloc(513);
    alloc(512);
    release_blk(512);
    release_blk(0);
    alloc(1023);
    release_blk(0);
    release_blk(1000);

    repeat (930) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        alloc($urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047));
      end else if (r < 6) begin
        release_blk($urandom_range(0, 1023));
      end else if (r < 55 || live_q.size() == 0) begin
        if ($urandom_range(0, 9) < 8) sz = $urandom_range(1, 64);
        else sz = $urandom_range(1, 1024);
        alloc(sz);
      end else begin
        release_blk(live_q[$urandom_range(0, live_q.size() - 1)]);
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (sb.pending_q.size() == 0);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d words: %0d ok results, %0d error results, cycles %0d.",
             words_sent, sb.n_ok, sb.n_err, cycles);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
